FILE: sv/ppg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppg_pkg
// Types and fixed-point constants of the plasma pixel generator: angle format,
// radian-to-turn scaling, reciprocal constants and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package ppg_pkg;

  // Angles are unsigned turns with this many fractional bits
  localparam int ANGLE_BITS = 12;

  // round(2^32 / (2*pi)): radians to turns in Q32
  localparam logic [29:0] RAD2TURN_Q32 = 30'd683565276;

  // Rounding shift of the radian-to-turn conversion
  localparam int TURN_SHIFT = 32 - ANGLE_BITS;

  // Rounding offsets den * 2^(TURN_SHIFT-1) for the three divided terms
  localparam logic [37:0] ROUND_X = 38'(7 * 2 ** (TURN_SHIFT - 1));
  localparam logic [37:0] ROUND_Y = 38'(5 * 2 ** (TURN_SHIFT - 1));
  localparam logic [38:0] ROUND_S = 39'(6 * 2 ** (TURN_SHIFT - 1));

  // Reciprocals ceil(2^22 / d), exact for dividends below 2^19
  localparam int          RECIP_SHIFT = 22;
  localparam logic [19:0] RECIP_7     = 20'd599187;
  localparam logic [19:0] RECIP_5     = 20'd838861;
  localparam logic [19:0] RECIP_6     = 20'd699051;

  // Radius term r/4 with r in Q4: a divide by 64 folds into the shift
  localparam int          RADIUS_SHIFT = TURN_SHIFT + 6;
  localparam logic [42:0] RADIUS_ROUND = 43'(2 ** (RADIUS_SHIFT - 1));

  // Pipeline geometry
  localparam int SQRT_STEPS = 13;
  localparam int NUM_STAGES = 19;

  // round(32768 * sin(k*pi/32)), k = 0..16
  localparam logic [15:0] QUARTER_SINE [0:16] = '{
    16'd0,     16'd3212,  16'd6393,  16'd9512,  16'd12540, 16'd15447,
    16'd18205, 16'd20788, 16'd23170, 16'd25330, 16'd27246, 16'd28899,
    16'd30274, 16'd31357, 16'd32138, 16'd32610, 16'd32768
  };

  typedef logic [ANGLE_BITS-1:0] angle_t;

  // Sine front end: table samples and interpolation fraction
  typedef struct packed {
    logic        neg;
    logic [15:0] lo;
    logic [11:0] diff;
    logic [9:0]  frac;
  } sine_a_t;

  // Sine magnitude after interpolation
  typedef struct packed {
    logic        neg;
    logic [15:0] mag;
  } sine_b_t;

endpackage

FILE: sv/plasma_pixel_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plasma_pixel_generator_top
// Plasma pixel generator: averages four table-based sine terms of the pixel
// coordinates, their sum, their radius and the animation phase.
// ----------------------------------------------------------------------------
// Usage:
//   Coordinate channel (coord_valid / coord_stall): one item carries
//   pixel_x, pixel_y and time_phase (4096 units per turn).
//   Pixel channel (pixel_valid / pixel_stall): one item carries the gray
//   level pixel_value, 0..254, in the order the coordinates came in.
//   Throughput is one item per clock while pixel_stall is low. The depth is
//   set by the 13-step integer square root of x*x + y*y, one result bit per
//   stage, plus constant multipliers and the sine interpolation stages.
//   Each stage holds a valid bit; a stage loads whenever it is empty or
//   the stage after it moves, so bubbles close up while the receiver stalls
//   and new items keep entering until every stage is full. Then coord_stall
//   rises in the same cycle and nothing is lost or repeated.
//   Reset (rst, synchronous) empties the pipeline; no item is in flight
//   after it. Coordinates cover the full 256 by 256 image.
// ----------------------------------------------------------------------------
module plasma_pixel_generator_top
  import ppg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       coord_valid,
  output logic       coord_stall,
  input  logic [7:0] pixel_x,
  input  logic [7:0] pixel_y,
  input  logic [11:0] time_phase,
  output logic       pixel_valid,
  input  logic       pixel_stall,
  output logic [7:0] pixel_value
);

  // Stage control
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   en;

  // Stage 0 registers
  logic [16:0] sq_v [0:SQRT_STEPS-1];
  logic [37:0] px;
  logic [37:0] py;
  logic [38:0] ps;
  angle_t      tt [0:14];

  // Stage 1 registers
  angle_t qx;
  angle_t qy;
  angle_t qs;

  // Square root state, stages 1..13
  logic [15:0] rem  [1:SQRT_STEPS];
  logic [12:0] root [1:SQRT_STEPS];

  // Angles, stages 2..14
  angle_t ang_x [2:14];
  angle_t ang_y [2:14];
  angle_t ang_s [2:14];

  // Stage 14: radius angle before the phase
  angle_t r_ang;

  // Sine stages 15..17 and output
  sine_a_t     sa [0:3];
  sine_b_t     sb [0:3];
  logic [7:0]  term [0:3];
  logic [7:0]  value;

  // Stage 0 combinational inputs
  logic [8:0]  xy_sum;
  logic [16:0] sq_sum;
  logic [37:0] mul_x;
  logic [37:0] mul_y;
  logic [38:0] mul_s;

  // Stage 1 products
  logic [37:0] div_x;
  logic [37:0] div_y;
  logic [38:0] div_s;

  // Stage 14 product
  logic [42:0] r_prod;

  // Stage 15 angles
  angle_t      sin_ang [0:3];

  // Front end of the sine: quadrant fold, table lookup and fraction
  function automatic sine_a_t sine_front(input angle_t ang);
    logic [15:0] a16;
    logic [14:0] folded;
    logic [4:0]  idx;
    sine_a_t     r;
    a16    = 16'(ang) << (16 - ANGLE_BITS);
    folded = {1'b0, a16[13:0]};
    if (a16[14]) begin
      folded = 15'h4000 - folded;
    end
    idx    = folded[14:10];
    r.frac = folded[9:0];
    r.neg  = a16[15];
    if (idx[4]) begin
      r.lo   = QUARTER_SINE[16];
      r.diff = '0;
    end else begin
      r.lo   = QUARTER_SINE[idx];
      r.diff = 12'(QUARTER_SINE[idx + 5'd1] - QUARTER_SINE[idx]);
    end
    return r;
  endfunction

  // Interpolate between the two table samples, rounding half up
  function automatic sine_b_t sine_interp(input sine_a_t a);
    logic [22:0] p;
    sine_b_t     r;
    p     = {11'b0, a.diff} * {13'b0, a.frac} + 23'd512;
    r.mag = a.lo + {3'b0, p[22:10]};
    r.neg = a.neg;
    return r;
  endfunction

  // Scale 32768 + s by 127/32768 and floor
  function automatic logic [7:0] sine_scale(input sine_b_t b);
    logic [16:0] off;
    logic [23:0] p;
    if (b.neg) begin
      off = 17'd32768 - {1'b0, b.mag};
    end else begin
      off = 17'd32768 + {1'b0, b.mag};
    end
    p = {off, 7'b0} - {7'b0, off};
    return p[22:15];
  endfunction

  // Load enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NUM_STAGES] = !pixel_stall;
    for (int p = NUM_STAGES - 1; p >= 0; p--) begin
      en[p] = !vld[p] || en[p+1];
    end
  end

  assign coord_stall = !en[0];
  assign pixel_valid = vld[NUM_STAGES-1];
  assign pixel_value = value;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= coord_valid;
      end
      for (int p = 1; p < NUM_STAGES; p++) begin
        if (en[p]) begin
          vld[p] <= vld[p-1];
        end
      end
    end
  end

  // Stage 0: squares and radian-to-turn products with rounding offsets
  always_comb begin
    xy_sum = {1'b0, pixel_x} + {1'b0, pixel_y};
    sq_sum = {9'b0, pixel_x} * {9'b0, pixel_x} + {9'b0, pixel_y} * {9'b0, pixel_y};
    mul_x  = {30'b0, pixel_x} * {8'b0, RAD2TURN_Q32} + ROUND_X;
    mul_y  = {30'b0, pixel_y} * {8'b0, RAD2TURN_Q32} + ROUND_Y;
    mul_s  = {30'b0, xy_sum} * {9'b0, RAD2TURN_Q32} + ROUND_S;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq_v[0] <= sq_sum;
      px      <= mul_x;
      py      <= mul_y;
      ps      <= mul_s;
      tt[0]   <= time_phase;
    end
  end

  // Stage 1: divide by 7, 5 and 6 through reciprocals, keep the turn bits
  always_comb begin
    div_x = {20'b0, px[37:TURN_SHIFT]} * {18'b0, RECIP_7};
    div_y = {20'b0, py[37:TURN_SHIFT]} * {18'b0, RECIP_5};
    div_s = {20'b0, ps[38:TURN_SHIFT]} * {19'b0, RECIP_6};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      qx <= div_x[RECIP_SHIFT+ANGLE_BITS-1:RECIP_SHIFT];
      qy <= div_y[RECIP_SHIFT+ANGLE_BITS-1:RECIP_SHIFT];
      qs <= div_s[RECIP_SHIFT+ANGLE_BITS-1:RECIP_SHIFT];
    end
  end

  // Stage 2: apply the phase
  always_ff @(posedge clk) begin
    if (en[2]) begin
      ang_x[2] <= qx + tt[1];
      ang_y[2] <= qy - tt[1];
      ang_s[2] <= qs - tt[1];
    end
  end

  // Carry the phase and the three angles down the pipe
  for (genvar p = 1; p <= 14; p++) begin : g_phase
    always_ff @(posedge clk) begin
      if (en[p]) begin
        tt[p] <= tt[p-1];
      end
    end
  end

  for (genvar p = 3; p <= 14; p++) begin : g_angle
    always_ff @(posedge clk) begin
      if (en[p]) begin
        ang_x[p] <= ang_x[p-1];
        ang_y[p] <= ang_y[p-1];
        ang_s[p] <= ang_s[p-1];
      end
    end
  end

  // Stages 1..13: square root of (x*x + y*y) * 256, one result bit a stage
  for (genvar p = 1; p <= SQRT_STEPS; p++) begin : g_sqrt
    localparam int PAIR = SQRT_STEPS - p;
    logic [25:0] operand;
    logic [15:0] rem_in;
    logic [12:0] root_in;
    logic [15:0] rem_sh;
    logic [15:0] trial;

    if (p == 1) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem[p-1];
      assign root_in = root[p-1];
    end

    assign operand = {1'b0, sq_v[p-1], 8'b0};
    assign rem_sh  = {rem_in[13:0], operand[2*PAIR+1 -: 2]};
    assign trial   = {1'b0, root_in, 2'b01};

    // Subtract the trial value when it fits, shift in the result bit
    always_ff @(posedge clk) begin
      if (en[p]) begin
        if (rem_sh >= trial) begin
          rem[p]  <= rem_sh - trial;
          root[p] <= {root_in[11:0], 1'b1};
        end else begin
          rem[p]  <= rem_sh;
          root[p] <= {root_in[11:0], 1'b0};
        end
      end
    end

    if (p < SQRT_STEPS) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[p]) begin
          sq_v[p] <= sq_v[p-1];
        end
      end
    end
  end

  // Stage 14: radius to turns
  assign r_prod = {30'b0, root[SQRT_STEPS]} * {13'b0, RAD2TURN_Q32} + RADIUS_ROUND;

  always_ff @(posedge clk) begin
    if (en[14]) begin
      r_ang <= r_prod[RADIUS_SHIFT+ANGLE_BITS-1:RADIUS_SHIFT];
    end
  end

  // Stage 15: fold the four angles and look up the table
  always_comb begin
    sin_ang[0] = ang_x[14];
    sin_ang[1] = ang_y[14];
    sin_ang[2] = ang_s[14];
    sin_ang[3] = r_ang - tt[14];
  end

  for (genvar i = 0; i < 4; i++) begin : g_sine
    always_ff @(posedge clk) begin
      if (en[15]) begin
        sa[i] <= sine_front(sin_ang[i]);
      end
      if (en[16]) begin
        sb[i] <= sine_interp(sa[i]);
      end
      if (en[17]) begin
        term[i] <= sine_scale(sb[i]);
      end
    end
  end

  // Stage 18: average the four terms
  always_ff @(posedge clk) begin
    if (en[18]) begin
      value <= 8'(({2'b0, term[0]} + {2'b0, term[1]} + {2'b0, term[2]}
                   + {2'b0, term[3]}) >> 2);
    end
  end

endmodule
